@@ hdl/lslf_pkg.sv @@
`timescale 1ns / 1ps
package lslf_pkg;

   // fixed field and accumulator widths
   localparam int VAL_W   = 24;
   localparam int SX_W    = 37;
   localparam int SXY_W   = 60;
   localparam int RES_W   = 32;
   localparam int STAT_W  = 3;
   localparam int WIDE_W  = 128;
   localparam int OP_W    = 64;
   localparam int CHUNK_W = 16;
   localparam int PP_W    = OP_W + CHUNK_W;
   localparam int CSR_IDX_W = 2;

   // abscissa limits, Q12.12
   localparam logic signed [VAL_W:0] ABS_MAX = 25'sd8388607;
   localparam logic signed [VAL_W:0] ABS_MIN = -25'sd8388608;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_ORIGIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_STEP   = 2'd1;

   // fit status codes
   localparam logic [STAT_W-1:0] FIT_NORMAL   = 3'd0;
   localparam logic [STAT_W-1:0] FIT_EMPTY    = 3'd1;
   localparam logic [STAT_W-1:0] FIT_SINGLE   = 3'd2;
   localparam logic [STAT_W-1:0] FIT_SINGULAR = 3'd3;
   localparam logic [STAT_W-1:0] FIT_OVERFLOW = 3'd4;

   // product selection: which term the shared multiplier forms
   typedef logic [2:0] mul_idx_type;
   localparam mul_idx_type MUL_N_SXX  = 3'd0;
   localparam mul_idx_type MUL_SX_SX  = 3'd1;
   localparam mul_idx_type MUL_N_SXY  = 3'd2;
   localparam mul_idx_type MUL_SX_SY  = 3'd3;
   localparam mul_idx_type MUL_SY_SXX = 3'd4;
   localparam mul_idx_type MUL_SX_SXY = 3'd5;

   // division selection
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_SINGLE = 2'd0;
   localparam div_sel_type DIV_SLOPE  = 2'd1;
   localparam div_sel_type DIV_ICEPT  = 2'd2;

   typedef struct packed {
      logic signed [VAL_W-1:0] sample;
      logic                    carries_sample;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] slope;
      logic signed [RES_W-1:0] intercept;
      logic [STAT_W-1:0]       fit_status;
   } rsp_type;

   typedef struct packed {
      logic        accept;
      logic        clear;
      logic        zero_res;
      logic        mul_start;
      mul_idx_type mul_idx;
      logic        div_start;
      div_sel_type div_sel;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic sx_zero;
      logic d_zero;
      logic overflowed;
      logic mul_done;
      logic div_done;
   } stat_type;

   // signed 32-bit saturation of a rounded quotient magnitude
   function automatic logic signed [RES_W-1:0] sat_quot(input logic [WIDE_W-1:0] q,
                                                       input logic neg);
      logic big;
      big = (q[WIDE_W-1:RES_W-1] != '0);
      if (neg) begin
         sat_quot = big ? {1'b1, {(RES_W-1){1'b0}}} : -q[RES_W-1:0];
      end else begin
         sat_quot = big ? {1'b0, {(RES_W-1){1'b1}}} : q[RES_W-1:0];
      end
   endfunction

endpackage

@@ hdl/lslf_ctrl.sv @@
`timescale 1ns / 1ps
module lslf_ctrl import lslf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   input  logic              rsp_stall,
   input  stat_type          stat,
   output logic              req_stall,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] fit_status,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_MUL_GO, ST_MUL_WAIT, ST_CHECK, ST_DIV_WAIT
   } state_type;

   state_type         state_ff, state_in;
   mul_idx_type       mul_idx_ff, mul_idx_in;
   div_sel_type       div_sel_ff, div_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              finish;
   logic [STAT_W-1:0] code;

   // a closing item waits while the previous result is still held
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && req_last);
   assign rsp_valid  = rsp_valid_ff;
   assign fit_status = status_ff;

   // sequencing of the fit
   always_comb begin
      state_in   = state_ff;
      mul_idx_in = mul_idx_ff;
      div_sel_in = div_sel_ff;
      cmd        = '0;
      finish     = 1'b0;
      code       = FIT_NORMAL;
      cmd.accept = req_valid && !req_stall;
      cmd.mul_idx = mul_idx_ff;
      cmd.div_sel = div_sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && req_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.zero_res = 1'b1;
            if (stat.n_zero) begin
               finish = 1'b1;
               code   = FIT_EMPTY;
            end else if (stat.n_one) begin
               code = FIT_SINGLE;
               if (stat.sx_zero) begin
                  finish = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_SINGLE;
                  div_sel_in    = DIV_SINGLE;
                  state_in      = ST_DIV_WAIT;
               end
            end else begin
               mul_idx_in = MUL_N_SXX;
               state_in   = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               if (mul_idx_ff == MUL_SX_SXY) begin
                  state_in = ST_CHECK;
               end else begin
                  mul_idx_in = mul_idx_ff + 3'd1;
                  state_in   = ST_MUL_GO;
               end
            end
         end
         ST_CHECK: begin
            if (stat.d_zero) begin
               finish = 1'b1;
               code   = FIT_SINGULAR;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SLOPE;
               div_sel_in    = DIV_SLOPE;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            code = (div_sel_ff == DIV_SINGLE) ? FIT_SINGLE : FIT_NORMAL;
            if (stat.div_done) begin
               if (div_sel_ff == DIV_SLOPE) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_ICEPT;
                  div_sel_in    = DIV_ICEPT;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         cmd.clear = 1'b1;
         state_in  = ST_IDLE;
      end
   end

   // result transfer flag and status
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         status_in    = stat.overflowed ? FIT_OVERFLOW : code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_idx_ff   <= MUL_N_SXX;
         div_sel_ff   <= DIV_SINGLE;
         rsp_valid_ff <= 1'b0;
         status_ff    <= FIT_NORMAL;
      end else begin
         state_ff     <= state_in;
         mul_idx_ff   <= mul_idx_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

endmodule

@@ hdl/lslf_datapath.sv @@
`timescale 1ns / 1ps
module lslf_datapath import lslf_pkg::*; #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  req_type                 req,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_data,
   output stat_type                stat,
   output logic signed [RES_W-1:0] slope,
   output logic signed [RES_W-1:0] intercept
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   // configuration and set state
   logic signed [VAL_W-1:0]  origin_ff, origin_in, step_ff, step_in;
   logic signed [VAL_W-1:0]  nabs_ff, nabs_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SX_W-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [SXY_W-1:0]  sum_xy_ff, sum_xy_in, sum_xx_ff, sum_xx_in;
   logic                     over_ff, over_in;
   logic signed [VAL_W:0]    nx;
   logic signed [2*VAL_W-1:0] xy, xx;
   logic                     take;

   // terms of the fit
   logic signed [WIDE_W-1:0] d_ff, d_in, kn_ff, kn_in, bn_ff, bn_in;

   // shared multiplier
   logic [OP_W-1:0]          ma_ff, ma_in, mb_ff, mb_in;
   logic                     mneg_ff, mneg_in, mbusy_ff, mbusy_in, mdone_ff, mdone_in;
   mul_idx_type              midx_ff, midx_in;
   logic [2:0]               mph_ff, mph_in;
   logic [PP_W-1:0]          pp_ff, pp_in;
   logic [WIDE_W-1:0]        pacc_ff, pacc_in, pp_sh, mfinal;
   logic signed [WIDE_W-1:0] prod;
   logic signed [OP_W-1:0]   opa, opb;
   logic [CHUNK_W-1:0]       chunk;

   // shared divider
   logic [WIDE_W-1:0]        num_ff, num_in, den_ff, den_in, q_ff, q_in;
   logic [WIDE_W:0]          rem_ff, rem_in, r_sh;
   logic                     dneg_ff, dneg_in, dbusy_ff, dbusy_in, ddone_ff, ddone_in;
   div_sel_type              dsel_ff, dsel_in;
   logic [6:0]               dcnt_ff, dcnt_in;
   logic signed [WIDE_W-1:0] dn, dd;
   logic [WIDE_W-1:0]        an, ad;
   logic                     ge;

   logic signed [RES_W-1:0]  k_ff, k_in, b_ff, b_in, qsat;

   assign slope     = k_ff;
   assign intercept = b_ff;

   assign stat.n_zero     = (cnt_ff == '0);
   assign stat.n_one      = (cnt_ff == CNT_W'(1));
   assign stat.sx_zero    = (sum_x_ff == '0);
   assign stat.d_zero     = (d_ff == '0);
   assign stat.overflowed = over_ff;
   assign stat.mul_done   = mdone_ff;
   assign stat.div_done   = ddone_ff;

   // sample accumulation and configuration
   always_comb begin
      origin_in = origin_ff;
      step_in   = step_ff;
      nabs_in   = nabs_ff;
      cnt_in    = cnt_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xy_in = sum_xy_ff;
      sum_xx_in = sum_xx_ff;
      over_in   = over_ff;
      xy = nabs_ff * req.sample;
      xx = nabs_ff * nabs_ff;
      nx = (VAL_W+1)'(nabs_ff) + (VAL_W+1)'(step_ff);
      take = cmd.accept && req.carries_sample;
      if (take) begin
         if (cnt_ff >= CNT_W'(MAX_SAMPLES)) begin
            over_in = 1'b1;
         end else begin
            sum_x_in  = sum_x_ff + SX_W'(nabs_ff);
            sum_y_in  = sum_y_ff + SX_W'(req.sample);
            sum_xy_in = sum_xy_ff + SXY_W'(xy);
            sum_xx_in = sum_xx_ff + SXY_W'(xx);
            cnt_in    = cnt_ff + CNT_W'(1);
            if (nx > ABS_MAX) begin
               nabs_in = ABS_MAX[VAL_W-1:0];
            end else if (nx < ABS_MIN) begin
               nabs_in = ABS_MIN[VAL_W-1:0];
            end else begin
               nabs_in = nx[VAL_W-1:0];
            end
         end
      end
      if (csr_write) begin
         case (csr_index)
            REG_X_ORIGIN: begin
               origin_in = csr_data;
               if (cnt_ff == '0) begin
                  nabs_in = csr_data;
               end
            end
            REG_X_STEP: step_in = csr_data;
            default: ;
         endcase
      end
      if (cmd.clear) begin
         cnt_in    = '0;
         sum_x_in  = '0;
         sum_y_in  = '0;
         sum_xy_in = '0;
         sum_xx_in = '0;
         over_in   = 1'b0;
         nabs_in   = origin_ff;
      end
   end

   // operand selection for the multiplier
   always_comb begin
      case (cmd.mul_idx)
         MUL_N_SXX:  begin opa = OP_W'(cnt_ff);   opb = OP_W'(sum_xx_ff); end
         MUL_SX_SX:  begin opa = OP_W'(sum_x_ff); opb = OP_W'(sum_x_ff);  end
         MUL_N_SXY:  begin opa = OP_W'(cnt_ff);   opb = OP_W'(sum_xy_ff); end
         MUL_SX_SY:  begin opa = OP_W'(sum_x_ff); opb = OP_W'(sum_y_ff);  end
         MUL_SY_SXX: begin opa = OP_W'(sum_y_ff); opb = OP_W'(sum_xx_ff); end
         MUL_SX_SXY: begin opa = OP_W'(sum_x_ff); opb = OP_W'(sum_xy_ff); end
         default:    begin opa = '0;              opb = '0;               end
      endcase
   end

   // multiplier: one 64 by 16 partial product a cycle, then accumulate
   always_comb begin
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      mneg_in  = mneg_ff;
      midx_in  = midx_ff;
      mph_in   = mph_ff;
      mbusy_in = mbusy_ff;
      mdone_in = 1'b0;
      pp_in    = pp_ff;
      pacc_in  = pacc_ff;
      d_in     = d_ff;
      kn_in    = kn_ff;
      bn_in    = bn_ff;
      case (mph_ff[1:0])
         2'd0:    chunk = mb_ff[15:0];
         2'd1:    chunk = mb_ff[31:16];
         2'd2:    chunk = mb_ff[47:32];
         default: chunk = mb_ff[63:48];
      endcase
      case (mph_ff)
         3'd1:    pp_sh = {48'b0, pp_ff};
         3'd2:    pp_sh = {32'b0, pp_ff, 16'b0};
         3'd3:    pp_sh = {16'b0, pp_ff, 32'b0};
         3'd4:    pp_sh = {pp_ff, 48'b0};
         default: pp_sh = '0;
      endcase
      mfinal = pacc_ff + pp_sh;
      prod   = mneg_ff ? -$signed(mfinal) : $signed(mfinal);
      if (cmd.mul_start) begin
         ma_in    = opa[OP_W-1] ? -opa : opa;
         mb_in    = opb[OP_W-1] ? -opb : opb;
         mneg_in  = opa[OP_W-1] ^ opb[OP_W-1];
         midx_in  = cmd.mul_idx;
         mph_in   = 3'd0;
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         if (mph_ff == 3'd4) begin
            mbusy_in = 1'b0;
            mdone_in = 1'b1;
            case (midx_ff)
               MUL_N_SXX:  d_in  = prod;
               MUL_SX_SX:  d_in  = d_ff - prod;
               MUL_N_SXY:  kn_in = prod;
               MUL_SX_SY:  kn_in = kn_ff - prod;
               MUL_SY_SXX: bn_in = prod;
               MUL_SX_SXY: bn_in = bn_ff - prod;
               default: ;
            endcase
         end else begin
            pp_in   = {16'b0, ma_ff} * {64'b0, chunk};
            pacc_in = (mph_ff == 3'd0) ? '0 : mfinal;
            mph_in  = mph_ff + 3'd1;
         end
      end
   end

   // numerator and denominator of a division
   always_comb begin
      case (cmd.div_sel)
         DIV_SINGLE: begin dn = WIDE_W'(sum_y_ff) <<< 16; dd = WIDE_W'(sum_x_ff); end
         DIV_SLOPE:  begin dn = kn_ff <<< 16;             dd = d_ff;              end
         DIV_ICEPT:  begin dn = bn_ff <<< 4;              dd = d_ff;              end
         default:    begin dn = '0;                       dd = '0;                end
      endcase
      an = dn[WIDE_W-1] ? -dn : dn;
      ad = dd[WIDE_W-1] ? -dd : dd;
   end

   // divider: restoring, one quotient bit a cycle, rounding via 2n+d over 2d
   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      dneg_in  = dneg_ff;
      dsel_in  = dsel_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      ddone_in = 1'b0;
      k_in     = k_ff;
      b_in     = b_ff;
      r_sh = {rem_ff[WIDE_W-1:0], num_ff[WIDE_W-1]};
      ge   = (r_sh >= {1'b0, den_ff});
      qsat = sat_quot({q_ff[WIDE_W-2:0], ge}, dneg_ff);
      if (cmd.zero_res) begin
         k_in = '0;
         b_in = '0;
      end
      if (cmd.div_start) begin
         num_in   = (an << 1) + ad;
         den_in   = ad << 1;
         rem_in   = '0;
         q_in     = '0;
         dneg_in  = dn[WIDE_W-1] ^ dd[WIDE_W-1];
         dsel_in  = cmd.div_sel;
         dcnt_in  = '0;
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         rem_in  = ge ? r_sh - {1'b0, den_ff} : r_sh;
         q_in    = {q_ff[WIDE_W-2:0], ge};
         num_in  = num_ff << 1;
         dcnt_in = dcnt_ff + 7'd1;
         if (dcnt_ff == 7'd127) begin
            dbusy_in = 1'b0;
            ddone_in = 1'b1;
            if (dsel_ff == DIV_ICEPT) begin
               b_in = qsat;
            end else begin
               k_in = qsat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         step_ff   <= VAL_W'(4096);
         nabs_ff   <= '0;
         cnt_ff    <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xy_ff <= '0;
         sum_xx_ff <= '0;
         over_ff   <= 1'b0;
         mbusy_ff  <= 1'b0;
         mdone_ff  <= 1'b0;
         dbusy_ff  <= 1'b0;
         ddone_ff  <= 1'b0;
      end else begin
         origin_ff <= origin_in;
         step_ff   <= step_in;
         nabs_ff   <= nabs_in;
         cnt_ff    <= cnt_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xy_ff <= sum_xy_in;
         sum_xx_ff <= sum_xx_in;
         over_ff   <= over_in;
         mbusy_ff  <= mbusy_in;
         mdone_ff  <= mdone_in;
         dbusy_ff  <= dbusy_in;
         ddone_ff  <= ddone_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      kn_ff   <= kn_in;
      bn_ff   <= bn_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      mneg_ff <= mneg_in;
      midx_ff <= midx_in;
      mph_ff  <= mph_in;
      pp_ff   <= pp_in;
      pacc_ff <= pacc_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dneg_ff <= dneg_in;
      dsel_ff <= dsel_in;
      dcnt_ff <= dcnt_in;
      k_ff    <= k_in;
      b_ff    <= b_in;
   end

endmodule

@@ hdl/least_squares_line_fit.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_data (sample, carries_sample, last)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data (slope, intercept, fit_status)
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// samples are taken one per cycle while req_stall is low; each is summed in the cycle of its transfer
// after a closing item with two or more samples, req_stall stays high while six
// products run on the shared 64x16 multiplier and, unless the determinant is zero,
// two 128-step divisions on the shared divider; one sample needs at most one division
// the next set streams in while a result waits; only its closing item is held
// reset is synchronous: sums cleared, x_origin 0, x_step 1.0
module least_squares_line_fit import lslf_pkg::*; #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   lslf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_last   (req_data.last),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .fit_status (rsp_data.fit_status),
      .cmd        (cmd)
   );

   // sums, multiplier and divider
   lslf_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .stat      (stat),
      .slope     (rsp_data.slope),
      .intercept (rsp_data.intercept)
   );

endmodule

@@ hdl/lslf_checker.sv @@
`timescale 1ns / 1ps
module lslf_checker import lslf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an empty set gives a zero line
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fit_status == FIT_EMPTY |->
         rsp_data.slope == '0 && rsp_data.intercept == '0)
      else $error("empty set with non-zero line");

   // a single sample has no intercept
   a_single_icept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fit_status == FIT_SINGLE |-> rsp_data.intercept == '0)
      else $error("single sample with intercept");

   // a closing transfer never lands on a pending result
   a_close_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |-> !rsp_valid ##1 !rsp_valid)
      else $error("closing item taken while result pending");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import lslf_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int FIT_LATENCY = 400;
   localparam int CAPACITY = 4096;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam longint Q_MAX = 8388607;
   localparam longint Q_MIN = -8388608;

   // predictor of the line fit and store of fits still to arrive
   class fit_board;
      longint origin, step;
      longint count, sx, sy, sxy, sxx, next_x;
      bit overflowed;
      rsp_type expected_fits[$];
      int errors;

      function new();
         origin = 0;
         step = 4096;
         errors = 0;
         clear_set();
      endfunction

      function void clear_set();
         count = 0;
         sx = 0;
         sy = 0;
         sxy = 0;
         sxx = 0;
         next_x = origin;
         overflowed = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
         if (idx == REG_X_ORIGIN) begin
            origin = longint'($signed(val));
            if (count == 0) next_x = origin;
         end else if (idx == REG_X_STEP) begin
            step = longint'($signed(val));
         end
      endfunction

      // rounded quotient, ties away from zero, saturated to 32 bits
      function logic signed [RES_W-1:0] round_div(logic signed [127:0] num,
                                                  logic signed [127:0] den);
         logic neg;
         logic [127:0] an, ad, q;
         neg = num[127] ^ den[127];
         an = num[127] ? -num : num;
         ad = den[127] ? -den : den;
         if (ad == 0) return 0;
         q = ((an << 1) + ad) / (ad << 1);
         if (neg) begin
            if (q >= 128'h8000_0000) return 32'sh8000_0000;
            return -q[31:0];
         end
         if (q > 128'h7fff_ffff) return 32'sh7fff_ffff;
         return q[31:0];
      endfunction

      function void note_input(req_type r);
         longint y, nx;
         logic signed [127:0] n, d, kn, bn;
         rsp_type fit;
         if (r.carries_sample) begin
            if (count >= CAPACITY) begin
               overflowed = 1;
            end else begin
               y = longint'(r.sample);
               sx += next_x;
               sy += y;
               sxy += next_x * y;
               sxx += next_x * next_x;
               count++;
               nx = next_x + step;
               if (nx > Q_MAX) nx = Q_MAX;
               if (nx < Q_MIN) nx = Q_MIN;
               next_x = nx;
            end
         end
         if (!r.last) return;
         fit = '0;
         n = 128'(count);
         if (count == 0) begin
            fit.fit_status = FIT_EMPTY;
         end else if (count == 1) begin
            fit.fit_status = FIT_SINGLE;
            fit.slope = round_div(128'(sy) * 65536, 128'(sx));
         end else begin
            d = n * 128'(sxx) - 128'(sx) * 128'(sx);
            if (d == 0) begin
               fit.fit_status = FIT_SINGULAR;
            end else begin
               kn = n * 128'(sxy) - 128'(sx) * 128'(sy);
               bn = 128'(sy) * 128'(sxx) - 128'(sx) * 128'(sxy);
               fit.fit_status = FIT_NORMAL;
               fit.slope = round_div(kn <<< 16, d);
               fit.intercept = round_div(bn <<< 4, d);
            end
         end
         if (overflowed) fit.fit_status = FIT_OVERFLOW;
         expected_fits.push_back(fit);
         clear_set();
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d, want %0d", what, got, want);
         errors++;
      endtask

      task check_result(rsp_type r);
         rsp_type w;
         if (expected_fits.size() == 0) begin
            report("unexpected fit", r.fit_status, -1);
            return;
         end
         w = expected_fits.pop_front();
         if (r.slope !== w.slope) report("slope", r.slope, w.slope);
         if (r.intercept !== w.intercept) report("intercept", r.intercept, w.intercept);
         if (r.fit_status !== w.fit_status) report("fit_status", r.fit_status, w.fit_status);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0] csr_data = '0;

   fit_board board = new();
   bit quiet = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_burst = 0;

   always #HALF_PERIOD clock = ~clock;

   least_squares_line_fit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // result transfers go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // receiver: random stall bursts and the occasional long hold-off
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = 900;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_burst = $urandom_range(0, 12);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // one input transfer; valid stays high for a following item
   task send_item(logic [VAL_W-1:0] value, bit carries, bit closes);
      req_type r;
      r.sample = value;
      r.carries_sample = carries;
      r.last = closes;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_input(r);
      @(negedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task wait_drained();
      req_valid <= 0;
      while (board.expected_fits.size() != 0) @(negedge clock);
      repeat (FIT_LATENCY) @(negedge clock);
   endtask

   function logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 3))
         0: return VAL_W'($urandom_range(0, 255) - 128);
         1: return VAL_W'(Q_MAX);
         2: return VAL_W'(Q_MIN);
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // random set with noise items, closing item with or without a sample
   task random_set(int length);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(VAL_W'($urandom), 1'b0, 1'b0);
         send_item(rand_value(), 1'b1, 1'b0);
      end
      send_item(rand_value(), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   task random_phase(logic [VAL_W-1:0] org, logic [VAL_W-1:0] stp, int sets);
      wait_drained();
      write_reg(REG_X_ORIGIN, org);
      write_reg(REG_X_STEP, stp);
      for (int s = 0; s < sets; s++) begin
         random_set(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 8));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: special cases at reset settings, then with a new origin and a zero step
      send_item('0, 1'b0, 1'b1);
      send_item(24'h000123, 1'b1, 1'b1);
      send_item(24'h000010, 1'b0, 1'b0);
      send_item(VAL_W'(Q_MAX), 1'b1, 1'b0);
      send_item(VAL_W'(Q_MIN), 1'b1, 1'b1);
      send_item(24'h001000, 1'b1, 1'b0);
      send_item(24'h002000, 1'b1, 1'b0);
      send_item('0, 1'b0, 1'b1);
      wait_drained();
      write_reg(REG_X_ORIGIN, 24'h004000);
      write_reg(REG_UNUSED, 24'hffffff);
      send_item(24'h7fffff, 1'b1, 1'b1);
      send_item(24'h800000, 1'b1, 1'b1);
      wait_drained();
      write_reg(REG_X_STEP, '0);
      send_item(24'h001000, 1'b1, 1'b0);
      send_item(24'h003000, 1'b1, 1'b1);
      send_item(24'h555555, 1'b1, 1'b0);
      send_item(24'haaaaaa, 1'b1, 1'b0);
      send_item(24'h000001, 1'b1, 1'b1);

      // random phases over several register settings
      random_phase('0, 24'h001000, 6);
      random_phase(24'h800000, 24'h7fffff, 5);
      random_phase(24'h7fffff, 24'h800000, 5);
      random_phase(VAL_W'($urandom), VAL_W'($urandom), 5);
      random_phase(VAL_W'($urandom), 24'h000001, 5);

      // long receiver hold-off while sets keep coming
      hold_requests++;
      for (int s = 0; s < 6; s++) random_set($urandom_range(1, 6));
      random_phase('0, 24'h001000, 2);
      random_phase(24'hffc000, 24'h000800, 4);

      // last part without idling or random receiver stalls
      wait_drained();
      quiet = 1;
      random_phase(VAL_W'($urandom), VAL_W'($urandom), 5);
      random_phase('0, 24'h001000, 5);

      wait_drained();
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #30ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ least_squares_line_fit.f @@
hdl/lslf_pkg.sv
hdl/lslf_ctrl.sv
hdl/lslf_datapath.sv
hdl/least_squares_line_fit.sv
hdl/lslf_checker.sv
tb/tb_top.sv
